// ===== hdl/hgp_pkg.sv =====
// hgp_pkg: constants and stage types of the henyey-greenstein phase unit
// no dependencies; used by henyey_greenstein_phase_unit
`default_nettype none

package hgp_pkg;

  localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;
  localparam logic [31:0] ISO_PDF_Q16 = 32'd5215;
  localparam logic [31:0] PDF_MAX     = 32'hFFFF_FFFF;

  localparam int unsigned SMP_DIV_STAGES = 16;
  localparam int unsigned COS_DIV_STAGES = 8;
  localparam int unsigned SQRT_STAGES    = 16;
  localparam int unsigned PDF_DIV_STAGES = 32;

  typedef struct packed {
    logic        iso;
    logic        func;
    logic [15:0] cos_pre;
  } meta_t;

  typedef struct packed {
    meta_t       meta;
    logic        sat;
    logic [32:0] den;
    logic [32:0] rem;
    logic [31:0] quo;
  } smp_div_t;

  typedef struct packed {
    meta_t       meta;
    logic        neg;
    logic        sat;
    logic [16:0] rem;
    logic [15:0] emag_lo;
    logic [15:0] quo;
  } cos_div_t;

  typedef struct packed {
    logic        iso;
    logic [15:0] cosv;
    logic [32:0] d;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic        iso;
    logic [15:0] cosv;
    logic        sat;
    logic [63:0] p;
    logic [63:0] rem;
    logic [31:0] quo;
  } pdf_div_t;

endpackage

`default_nettype wire

// ===== hdl/henyey_greenstein_phase_unit.sv =====
// henyey_greenstein_phase_unit: pipelined henyey-greenstein pdf evaluation and sampling
// depends on hgp_pkg
`default_nettype none

// Takes one transaction per clock while not stalled and returns one result per
// transaction, in order. The pipeline is a chain of restoring stages: the
// inverse-cdf quotient (2 bits a stage), the cosine quotient (2 bits a stage), the
// integer square root (2 bits a stage) and the 32-bit density quotient (1 bit a
// stage). A held result stalls the whole pipeline, so in_stall_o follows
// out_stall_i while a result is waiting. asymmetry_g may only be written while no
// transaction is in flight; g equal to zero gives the isotropic density.
module henyey_greenstein_phase_unit import hgp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic signed [15:0] asymmetry_g_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               func_i,
  input  wire logic signed [15:0] cosine_in_i,
  input  wire logic        [15:0] uniform_xi_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic             [31:0] pdf_value_o,
  output logic signed      [15:0] cosine_out_o,
  output logic                    saturated_o
);

  logic adv;

  // configuration and derived constants
  logic signed [15:0] g_q;
  logic        [30:0] g2_q;
  logic        [30:0] num;
  logic        [59:0] nk_q;
  logic        [16:0] gmag2;
  logic        [16:0] g2x;

  assign cfg_ready_o = 1'b1;
  assign num   = 31'h4000_0000 - g2_q;
  assign g2x   = {g_q, 1'b0};
  assign gmag2 = g_q[15] ? 17'(-g2x) : g2x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
    end else if (cfg_valid_i) begin
      g_q <= asymmetry_g_i;
    end
  end

  always_ff @(posedge clk_i) begin
    g2_q <= 31'(g_q * g_q);
    nk_q <= {29'b0, num} * {31'b0, INV_4PI_Q32};
  end

  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // stage 1: meta and xi product
  logic               s1_v_q;
  meta_t              s1_meta_q;
  logic signed [33:0] s1_gx_q;
  logic signed [18:0] xm;
  logic signed [34:0] gx_full;
  meta_t              s1_meta_d;

  assign xm      = $signed({2'b00, uniform_xi_i, 1'b0}) - 19'sd65536;
  assign gx_full = g_q * xm;

  always_comb begin
    s1_meta_d.iso     = (g_q == 16'sd0);
    s1_meta_d.func    = func_i;
    s1_meta_d.cos_pre = func_i ? (uniform_xi_i ^ 16'h8000) : cosine_in_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q <= s1_meta_d;
      s1_gx_q   <= gx_full[33:0];
    end
  end

  // inverse-cdf quotient
  smp_div_t                  d1_q [0:SMP_DIV_STAGES];
  logic [SMP_DIV_STAGES:0]   d1v_q;
  smp_div_t                  d1_d;
  logic signed [34:0]        den_s;

  always_comb begin
    den_s         = 35'sh0_8000_0000 + 35'(s1_gx_q);
    d1_d.meta     = s1_meta_q;
    d1_d.den      = (den_s < 35'sd1) ? 33'd1 : den_s[32:0];
    d1_d.rem      = {3'b000, num[30:1]};
    d1_d.sat      = (d1_d.rem >= d1_d.den);
    d1_d.quo      = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q[0] <= d1_d;
    end
  end

  for (genvar k = 0; k < SMP_DIV_STAGES; k++) begin : g_smp_div
    smp_div_t nx;
    always_comb begin
      logic [33:0] tr;
      nx = d1_q[k];
      for (int b = 0; b < 2; b++) begin
        tr = {nx.rem, ((31 - 2*k - b) == 31) ? num[0] : 1'b0};
        if (tr >= {1'b0, nx.den}) begin
          nx.rem = 33'(tr - {1'b0, nx.den});
          nx.quo[31 - 2*k - b] = 1'b1;
        end else begin
          nx.rem = tr[32:0];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_q[k+1] <= nx;
      end
    end
  end

  // t clamp, t squared, cosine numerator, magnitude split
  meta_t       t_meta_q, m_meta_q, e_meta_q;
  logic [31:0] t_q;
  logic [63:0] tt_q;
  logic [34:0] e_q;
  logic        t_v_q, m_v_q, e_v_q;
  logic [32:0] emag;
  cos_div_t    d2_d;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t_meta_q <= d1_q[SMP_DIV_STAGES].meta;
      t_q      <= (d1_q[SMP_DIV_STAGES].sat || d1_q[SMP_DIV_STAGES].quo > 32'h8000_0000)
                  ? 32'h8000_0000 : d1_q[SMP_DIV_STAGES].quo;
      m_meta_q <= t_meta_q;
      tt_q     <= t_q * t_q;
      e_meta_q <= m_meta_q;
      e_q      <= 35'h0_4000_0000 + {4'b0, g2_q} - {1'b0, tt_q[63:30]};
    end
  end

  always_comb begin
    emag         = e_q[34] ? 33'(-e_q) : e_q[32:0];
    d2_d.meta    = e_meta_q;
    d2_d.neg     = e_q[34] ^ g_q[15];
    d2_d.rem     = emag[32:16];
    d2_d.sat     = (emag[32:16] >= gmag2);
    d2_d.emag_lo = emag[15:0];
    d2_d.quo     = '0;
  end

  // cosine quotient
  cos_div_t                d2_q [0:COS_DIV_STAGES];
  logic [COS_DIV_STAGES:0] d2v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q[0] <= d2_d;
    end
  end

  for (genvar k = 0; k < COS_DIV_STAGES; k++) begin : g_cos_div
    cos_div_t nx;
    always_comb begin
      logic [17:0] tr;
      nx = d2_q[k];
      for (int b = 0; b < 2; b++) begin
        tr = {nx.rem, nx.emag_lo[15 - 2*k - b]};
        if (tr >= {1'b0, gmag2}) begin
          nx.rem = 17'(tr - {1'b0, gmag2});
          nx.quo[15 - 2*k - b] = 1'b1;
        end else begin
          nx.rem = tr[16:0];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d2_q[k+1] <= nx;
      end
    end
  end

  // cosine select, then density argument
  cos_div_t    cf;
  logic [15:0] comp;
  logic [15:0] c_cos_q, p1_cos_q;
  logic        c_iso_q, p1_iso_q;
  logic        c_v_q, p1_v_q;
  logic signed [31:0] gc;
  logic signed [31:0] gc_q;
  logic        [34:0] ds;
  sqrt_t              sq_d;

  always_comb begin
    cf = d2_q[COS_DIV_STAGES];
    if (cf.sat) begin
      comp = cf.neg ? 16'h8000 : 16'h7FFF;
    end else if (cf.neg) begin
      comp = (cf.quo > 16'd32768) ? 16'h8000 : 16'(-cf.quo);
    end else begin
      comp = (cf.quo > 16'd32767) ? 16'h7FFF : cf.quo;
    end
  end

  assign gc = g_q * $signed(c_cos_q);
  assign ds = 35'h0_4000_0000 + {4'b0, g2_q} - {{2{gc_q[31]}}, gc_q, 1'b0};

  always_comb begin
    sq_d.iso  = p1_iso_q;
    sq_d.cosv = p1_cos_q;
    sq_d.d    = ds[32:0];
    sq_d.rem  = '0;
    sq_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_iso_q  <= cf.meta.iso;
      c_cos_q  <= (cf.meta.func && !cf.meta.iso) ? comp : cf.meta.cos_pre;
      p1_iso_q <= c_iso_q;
      p1_cos_q <= c_cos_q;
      gc_q     <= gc;
    end
  end

  // square root of d * 2^30
  sqrt_t                sq_q [0:SQRT_STAGES];
  logic [SQRT_STAGES:0] sqv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q[0] <= sq_d;
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    sqrt_t nx;
    always_comb begin
      logic [63:0] rad;
      logic [35:0] tr;
      logic [35:0] trial;
      nx  = sq_q[k];
      rad = {1'b0, nx.d, 30'b0};
      for (int b = 0; b < 2; b++) begin
        tr    = {nx.rem, rad[2*(31 - 2*k - b) +: 2]};
        trial = {2'b00, nx.root, 2'b01};
        if (tr >= trial) begin
          nx.rem  = 34'(tr - trial);
          nx.root = {nx.root[30:0], 1'b1};
        end else begin
          nx.rem  = tr[33:0];
          nx.root = {nx.root[30:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k+1] <= nx;
      end
    end
  end

  // d * s in two partial products
  logic [48:0] pa_q, pb_q;
  logic [63:0] p_q;
  logic [15:0] pm_cos_q, ps_cos_q;
  logic        pm_iso_q, ps_iso_q;
  logic        pm_v_q, ps_v_q;
  pdf_div_t    d3_d;
  logic [31:0] xlo;

  assign xlo = {nk_q[17:0], 14'b0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q     <= sq_q[SQRT_STAGES].d * sq_q[SQRT_STAGES].root[15:0];
      pb_q     <= sq_q[SQRT_STAGES].d * sq_q[SQRT_STAGES].root[31:16];
      pm_iso_q <= sq_q[SQRT_STAGES].iso;
      pm_cos_q <= sq_q[SQRT_STAGES].cosv;
      p_q      <= 64'({15'b0, pa_q} + {pb_q, 16'b0});
      ps_iso_q <= pm_iso_q;
      ps_cos_q <= pm_cos_q;
    end
  end

  always_comb begin
    d3_d.iso  = ps_iso_q;
    d3_d.cosv = ps_cos_q;
    d3_d.p    = p_q;
    d3_d.rem  = {22'b0, nk_q[59:18]};
    d3_d.sat  = (d3_d.rem >= p_q);
    d3_d.quo  = '0;
  end

  // density quotient
  pdf_div_t                d3_q [0:PDF_DIV_STAGES];
  logic [PDF_DIV_STAGES:0] d3v_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_q[0] <= d3_d;
    end
  end

  for (genvar k = 0; k < PDF_DIV_STAGES; k++) begin : g_pdf_div
    pdf_div_t nx;
    always_comb begin
      logic [64:0] tr;
      nx = d3_q[k];
      tr = {nx.rem, xlo[31 - k]};
      if (tr >= {1'b0, nx.p}) begin
        nx.rem = 64'(tr - {1'b0, nx.p});
        nx.quo[31 - k] = 1'b1;
      end else begin
        nx.rem = tr[63:0];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        d3_q[k+1] <= nx;
      end
    end
  end

  // output register
  pdf_div_t    fo;
  logic [31:0] pdf_q;
  logic [15:0] cos_q;
  logic        sat_q;

  assign fo = d3_q[PDF_DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pdf_q <= fo.iso ? ISO_PDF_Q16 : (fo.sat ? PDF_MAX : fo.quo);
      sat_q <= !fo.iso && fo.sat;
      cos_q <= fo.cosv;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      d1v_q       <= '0;
      t_v_q       <= 1'b0;
      m_v_q       <= 1'b0;
      e_v_q       <= 1'b0;
      d2v_q       <= '0;
      c_v_q       <= 1'b0;
      p1_v_q      <= 1'b0;
      sqv_q       <= '0;
      pm_v_q      <= 1'b0;
      ps_v_q      <= 1'b0;
      d3v_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= in_valid_i;
      d1v_q       <= {d1v_q[SMP_DIV_STAGES-1:0], s1_v_q};
      t_v_q       <= d1v_q[SMP_DIV_STAGES];
      m_v_q       <= t_v_q;
      e_v_q       <= m_v_q;
      d2v_q       <= {d2v_q[COS_DIV_STAGES-1:0], e_v_q};
      c_v_q       <= d2v_q[COS_DIV_STAGES];
      p1_v_q      <= c_v_q;
      sqv_q       <= {sqv_q[SQRT_STAGES-1:0], p1_v_q};
      pm_v_q      <= sqv_q[SQRT_STAGES];
      ps_v_q      <= pm_v_q;
      d3v_q       <= {d3v_q[PDF_DIV_STAGES-1:0], ps_v_q};
      out_valid_q <= d3v_q[PDF_DIV_STAGES];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pdf_value_o  = pdf_q;
  assign cosine_out_o = cos_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire

// ===== hdl/hgp_checker.sv =====
// hgp_checker: port-level assertions for henyey_greenstein_phase_unit
// no dependencies; bound to the top level at the end of this file
`default_nettype none

module hgp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_valid_i,
  input wire logic               cfg_ready_o,
  input wire logic signed [15:0] asymmetry_g_i,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               func_i,
  input wire logic signed [15:0] cosine_in_i,
  input wire logic        [15:0] uniform_xi_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic        [31:0] pdf_value_o,
  input wire logic signed [15:0] cosine_out_o,
  input wire logic               saturated_o
);

  // input only held back by a waiting result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // saturation flag goes with the clamped density
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (pdf_value_o == 32'hFFFF_FFFF))
    else $error("saturated transaction without maximum density");

  // held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(pdf_value_o) && $stable(cosine_out_o) && $stable(saturated_o)))
    else $error("held transaction changed");

endmodule

bind henyey_greenstein_phase_unit hgp_checker u_hgp_checker (.*);

`default_nettype wire
